/* hdl/dsso_pkg.sv */
package dsso_pkg;

   // field widths
   localparam int VALUE_W = 16;
   localparam int CSR_W   = 4;
   localparam int POS_W   = 3;
   localparam int SEG_BITS = 8;

   // configuration defaults
   localparam logic [CSR_W-1:0] DIGIT_COUNT_RESET = 4'd4;
   localparam int MAX_DIGITS_DEF = 8;
   localparam int QUEUE_DEPTH    = 2;

   // last bit index within one segment pattern
   localparam logic [POS_W-1:0] SEG_LAST = 3'd7;

   // x / 10 == (x * 52429) >> 19 for every 16-bit x
   localparam logic [15:0] DIV10_MUL   = 16'd52429;
   localparam int          DIV10_SHIFT = 19;

   // active-low PGFEDCBA pattern, decimal point off
   function automatic logic [SEG_BITS-1:0] seg_pattern(input logic [3:0] digit);
      logic [SEG_BITS-1:0] lit;
      unique case (digit)
         4'd0:    lit = 8'h3F;
         4'd1:    lit = 8'h06;
         4'd2:    lit = 8'h5B;
         4'd3:    lit = 8'h4F;
         4'd4:    lit = 8'h66;
         4'd5:    lit = 8'h6D;
         4'd6:    lit = 8'h7D;
         4'd7:    lit = 8'h07;
         4'd8:    lit = 8'h7F;
         4'd9:    lit = 8'h6F;
         default: lit = 8'h00;
      endcase
      return ~lit;
   endfunction

endpackage

/* hdl/dsso_front.sv */
module dsso_front #(
   parameter int MAX_DIGITS = dsso_pkg::MAX_DIGITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [dsso_pkg::VALUE_W-1:0]           req_value,
   input  logic [dsso_pkg::POS_W-1:0]             ndig_m1,
   input  logic                                   queue_full,
   output logic                                   queue_push,
   output logic [dsso_pkg::POS_W+MAX_DIGITS*dsso_pkg::SEG_BITS-1:0] queue_entry
);
   import dsso_pkg::*;

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   typedef enum logic [1:0] {IDLE, CONV, PUSH} state_type;

   state_type            state_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [POS_W-1:0]     cnt_ff;
   logic [POS_W-1:0]     last_ff;
   logic [SEG_BITS-1:0]  pat_ff [MAX_DIGITS];

   logic [31:0]          prod;
   logic [VALUE_W-1:0]   quot;
   logic [VALUE_W-1:0]   ten_quot;
   logic [VALUE_W-1:0]   rem;
   logic                 accept;

   // one decimal digit per cycle: reciprocal multiply, then remainder
   assign prod     = 32'(value_ff) * 32'(DIV10_MUL);
   assign quot     = VALUE_W'(prod >> DIV10_SHIFT);
   assign ten_quot = VALUE_W'({quot, 3'b000}) + VALUE_W'({quot, 1'b0});
   assign rem      = value_ff - ten_quot;

   // take a new value when idle or while the finished one is leaving
   assign req_ready  = (state_ff == IDLE) || ((state_ff == PUSH) && !queue_full);
   assign accept     = req_valid && req_ready;
   assign queue_push = (state_ff == PUSH) && !queue_full;

   always_comb begin
      queue_entry[POS_W+MAX_DIGITS*SEG_BITS-1 -: POS_W] = last_ff;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         queue_entry[i*SEG_BITS +: SEG_BITS] = pat_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         if (accept) begin
            value_ff <= req_value;
            cnt_ff   <= '0;
            last_ff  <= ndig_m1;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept) state_ff <= CONV;
            end
            CONV: begin
               pat_ff[cnt_ff[IDX_W-1:0]] <= seg_pattern(rem[3:0]);
               value_ff <= quot;
               cnt_ff   <= cnt_ff + POS_W'(1);
               if (cnt_ff == last_ff) state_ff <= PUSH;
            end
            PUSH: begin
               if (!queue_full) begin
                  state_ff <= accept ? CONV : IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

/* hdl/dsso_fifo.sv */
module dsso_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = dsso_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   import dsso_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

/* hdl/dsso_back.sv */
module dsso_back #(
   parameter int MAX_DIGITS = dsso_pkg::MAX_DIGITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   queue_empty,
   output logic                                   queue_pop,
   input  logic [dsso_pkg::POS_W+MAX_DIGITS*dsso_pkg::SEG_BITS-1:0] queue_entry,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_data_bit,
   output logic                                   rsp_clear_first,
   output logic [dsso_pkg::POS_W-1:0]             rsp_digit_position,
   output logic [dsso_pkg::POS_W-1:0]             rsp_segment_index,
   output logic                                   rsp_last
);
   import dsso_pkg::*;

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   logic                 active_ff;
   logic [SEG_BITS-1:0]  pat_ff [MAX_DIGITS];
   logic [POS_W-1:0]     ndig_m1_ff;
   logic [POS_W-1:0]     dig_ff;
   logic [POS_W-1:0]     seg_ff;

   logic                 rsp_valid_ff;
   logic                 data_bit_ff;
   logic                 clear_first_ff;
   logic [POS_W-1:0]     digit_pos_ff;
   logic [POS_W-1:0]     seg_index_ff;
   logic                 last_ff;

   logic                 out_free;
   logic                 step;
   logic                 item_end;
   logic [SEG_BITS-1:0]  cur_pat;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = active_ff && out_free;
   assign item_end  = (dig_ff == ndig_m1_ff) && (seg_ff == SEG_LAST);
   assign queue_pop = !queue_empty && (!active_ff || (step && item_end));
   assign cur_pat   = pat_ff[dig_ff[IDX_W-1:0]];

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_bit       = data_bit_ff;
   assign rsp_clear_first    = clear_first_ff;
   assign rsp_digit_position = digit_pos_ff;
   assign rsp_segment_index  = seg_index_ff;
   assign rsp_last           = last_ff;

   // control: item in progress and output slot occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (queue_pop) begin
            active_ff <= 1'b1;
         end else if (step && item_end) begin
            active_ff <= 1'b0;
         end
      end
   end

   // shift sequencer and output register
   always_ff @(posedge clock) begin
      if (step) begin
         data_bit_ff    <= cur_pat[seg_ff];
         clear_first_ff <= (dig_ff == '0) && (seg_ff == '0);
         digit_pos_ff   <= dig_ff;
         seg_index_ff   <= seg_ff;
         last_ff        <= item_end;
      end
      // a new entry restarts the counters, otherwise advance one bit
      if (queue_pop) begin
         ndig_m1_ff <= queue_entry[POS_W+MAX_DIGITS*SEG_BITS-1 -: POS_W];
         dig_ff     <= '0;
         seg_ff     <= '0;
         for (int i = 0; i < MAX_DIGITS; i++) begin
            pat_ff[i] <= queue_entry[i*SEG_BITS +: SEG_BITS];
         end
      end else if (step) begin
         if (seg_ff == SEG_LAST) begin
            seg_ff <= '0;
            dig_ff <= dig_ff + POS_W'(1);
         end else begin
            seg_ff <= seg_ff + POS_W'(1);
         end
      end
   end

endmodule

/* hdl/decimal_seven_segment_shift_out_core.sv */
// Channel   Direction  Handshake        Payload
// req       in         valid / ready    value (16)
// rsp       out        valid / ready    data_bit, clear_first, digit_position (3),
//                                       segment_index (3), last
// csr       in         write enable     digit_count (4), reset value 4
//
// Each value yields 8 * N transfers on rsp, N = digit_count clamped to 1..MAX_DIGITS;
// the output sequencer sends one bit per cycle unless rsp stalls. The front
// converts one decimal digit per cycle and runs ahead through a two-entry
// queue. Reset is synchronous and empties front, queue and output. A stalled
// rsp holds its transfer; the front keeps accepting until the queue fills.
module decimal_seven_segment_shift_out_core #(
   parameter int MAX_DIGITS = dsso_pkg::MAX_DIGITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [dsso_pkg::VALUE_W-1:0]   req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_data_bit,
   output logic                           rsp_clear_first,
   output logic [dsso_pkg::POS_W-1:0]     rsp_digit_position,
   output logic [dsso_pkg::POS_W-1:0]     rsp_segment_index,
   output logic                           rsp_last,
   input  logic                           csr_we,
   input  logic [dsso_pkg::CSR_W-1:0]     csr_wdata
);
   import dsso_pkg::*;

   localparam int ENTRY_W = POS_W + MAX_DIGITS * SEG_BITS;

   logic [CSR_W-1:0] digit_count_ff;
   logic [POS_W-1:0] ndig_m1;
   logic             queue_push;
   logic             queue_full;
   logic             queue_pop;
   logic             queue_empty;
   logic [ENTRY_W-1:0] push_entry;
   logic [ENTRY_W-1:0] pop_entry;

   // digit count register
   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= DIGIT_COUNT_RESET;
      end else if (csr_we) begin
         digit_count_ff <= csr_wdata;
      end
   end

   // clamp to 1..MAX_DIGITS, kept as count minus one
   always_comb begin
      if (digit_count_ff == '0) begin
         ndig_m1 = '0;
      end else if (digit_count_ff > CSR_W'(MAX_DIGITS)) begin
         ndig_m1 = POS_W'(MAX_DIGITS - 1);
      end else begin
         ndig_m1 = POS_W'(digit_count_ff - CSR_W'(1));
      end
   end

   dsso_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_value   (req_value),
      .ndig_m1     (ndig_m1),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_entry (push_entry)
   );

   dsso_fifo #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_entry),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (pop_entry),
      .empty     (queue_empty)
   );

   dsso_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_empty        (queue_empty),
      .queue_pop          (queue_pop),
      .queue_entry        (pop_entry),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_data_bit       (rsp_data_bit),
      .rsp_clear_first    (rsp_clear_first),
      .rsp_digit_position (rsp_digit_position),
      .rsp_segment_index  (rsp_segment_index),
      .rsp_last           (rsp_last)
   );

endmodule

/* hdl/dsso_checker.sv */
module dsso_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [dsso_pkg::VALUE_W-1:0]   req_value,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_data_bit,
   input logic                           rsp_clear_first,
   input logic [dsso_pkg::POS_W-1:0]     rsp_digit_position,
   input logic [dsso_pkg::POS_W-1:0]     rsp_segment_index,
   input logic                           rsp_last,
   input logic                           csr_we,
   input logic [dsso_pkg::CSR_W-1:0]     csr_wdata
);
   import dsso_pkg::*;

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_bit)
         && $stable(rsp_clear_first) && $stable(rsp_digit_position)
         && $stable(rsp_segment_index) && $stable(rsp_last))
      else $error("rsp payload changed while stalled");

   // the first bit of a value is bit 0 of digit 0
   a_clear_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clear_first |-> rsp_digit_position == '0 && rsp_segment_index == '0)
      else $error("clear_first away from the first bit");

   // a value always ends on a pattern boundary
   a_last_seg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_segment_index == SEG_LAST)
      else $error("last not on the final segment bit");

   // decimal point is always dark (active-low 1)
   a_dp_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_segment_index == SEG_LAST |-> rsp_data_bit)
      else $error("decimal point bit driven low");

   // after a final bit is taken the next transfer opens a new value
   a_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last ##1 rsp_valid |-> rsp_clear_first)
      else $error("new value without clear_first");

endmodule

bind decimal_seven_segment_shift_out_core dsso_checker u_dsso_checker (.*);
